@@ hw/rtl/pwli_pkg.sv @@
`default_nettype none
package pwli_pkg;

    localparam int KEY_W       = 24;
    localparam int VAL_W       = 40;
    localparam int BP_W        = 64;
    localparam int PC_W        = 3;
    localparam int NUM_BP_REGS = 7;
    localparam int CFG_ADDR_W  = 4;
    localparam int PROD_W      = 64;
    localparam int SMALL_W     = 24;
    localparam int MUL_STEPS   = 3;
    localparam int DIV_STEPS   = 40;
    localparam int DIV_CNT_W   = 6;

    localparam int MAX_POINTS_DEFAULT = 7;

    localparam logic [CFG_ADDR_W-1:0] REG_POINT_COUNT = CFG_ADDR_W'(7);
    localparam logic [PC_W-1:0]       POINT_COUNT_RESET = 3'd7;

    localparam logic [BP_W-1:0] BP_RESET [NUM_BP_REGS] = '{
        64'd0,
        64'd720575940379304960,
        64'd2017612633062238208,
        64'd3458764513821308928,
        64'd4683743612470435840,
        64'd5980780305199218688,
        64'd7205759404304793600
    };

    typedef enum logic [1:0] {
        STATUS_INTERP     = 2'd0,
        STATUS_CLAMP_LOW  = 2'd1,
        STATUS_CLAMP_HIGH = 2'd2,
        STATUS_FAULT      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HIGH,
        ST_LOW,
        ST_SEARCH,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [VAL_W-1:0] dom;
        logic [VAL_W-1:0] rng;
    } point_t;

    function automatic point_t map_point(input logic [BP_W-1:0] bp, input logic inverse);
        point_t p;
        if (inverse)
        begin
            p.dom = bp[VAL_W-1:0];
            p.rng = VAL_W'(bp[BP_W-1:VAL_W]);
        end
        else
        begin
            p.dom = VAL_W'(bp[BP_W-1:VAL_W]);
            p.rng = bp[VAL_W-1:0];
        end
        return p;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/pwli_ifs.sv @@
`default_nettype none
interface pwli_req_if;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [pwli_pkg::VAL_W-1:0] input_value;

    modport source (output valid, output opcode, output input_value, input ready);
    modport sink   (input valid, input opcode, input input_value, output ready);
endinterface

interface pwli_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [pwli_pkg::VAL_W-1:0] result_value;
    logic [1:0]                 status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

interface pwli_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pwli_pkg::CFG_ADDR_W-1:0] addr;
    logic [pwli_pkg::BP_W-1:0]       data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/pwli_div.sv @@
`default_nettype none
module pwli_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [pwli_pkg::PROD_W-1:0]   dividend,
    input  wire logic [pwli_pkg::VAL_W-1:0]    divisor,
    output logic                               done,
    output logic [pwli_pkg::VAL_W-1:0]         quotient
);

    localparam int W  = pwli_pkg::VAL_W;
    localparam int CW = pwli_pkg::DIV_CNT_W;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  low_reg, low_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [W:0]    trial;
    logic          fits;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, low_reg[W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        low_next  = low_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            cnt_next = CW'(pwli_pkg::DIV_STEPS);
            rem_next = W'(dividend[pwli_pkg::PROD_W-1:W]);
            low_next = dividend[W-1:0];
            dsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CW'(1);
            rem_next  = fits ? W'(trial - {1'b0, dsr_reg}) : trial[W-1:0];
            low_next  = {low_reg[W-2:0], fits};
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = low_reg;

endmodule
`default_nettype wire

@@ hw/rtl/piecewise_linear_table_interp_core.sv @@
// Flow: an accepted item reads the last and then the first breakpoint; clamped items go
//   straight to the result, interpolated items walk the intervals, multiply and then divide.
// Throughput: one item at a time, the next can be accepted in the cycle after the result
//   is posted; the restoring divider dominates.
// Reset: rst_n asynchronous, active low; breakpoints and point count take their
//   default values, the sequencer returns to idle and no result is pending.
`default_nettype none
module piecewise_linear_table_interp_core #(
    parameter int MAX_POINTS = pwli_pkg::MAX_POINTS_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pwli_req_if.sink   req,
    pwli_rsp_if.source rsp,
    pwli_cfg_if.sink   cfg
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int VW    = pwli_pkg::VAL_W;
    localparam int PW    = pwli_pkg::PROD_W;
    localparam int SW    = pwli_pkg::SMALL_W;
    localparam int AW    = pwli_pkg::CFG_ADDR_W;
    localparam logic [pwli_pkg::PC_W-1:0] MAX_N = pwli_pkg::PC_W'(MAX_POINTS);

    // configuration
    logic [pwli_pkg::BP_W-1:0] bp_reg [MAX_POINTS];
    logic [pwli_pkg::PC_W-1:0] pc_reg;
    logic                      cfg_wr;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;

    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_bp
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                bp_reg[i] <= pwli_pkg::BP_RESET[i];
            else if (cfg_wr && cfg.addr == AW'(i))
                bp_reg[i] <= cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= pwli_pkg::POINT_COUNT_RESET;
        else if (cfg_wr && cfg.addr == pwli_pkg::REG_POINT_COUNT)
            pc_reg <= cfg.data[pwli_pkg::PC_W-1:0];
    end

    logic [pwli_pkg::PC_W-1:0] n_act;
    logic [IDX_W-1:0]          n_last;

    always_comb
    begin
        if (pc_reg < 3'd2)
            n_act = 3'd2;
        else if (pc_reg > MAX_N)
            n_act = MAX_N;
        else
            n_act = pc_reg;
    end
    assign n_last = IDX_W'(n_act - 3'd1);

    // sequencer state
    pwli_pkg::state_t  state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [1:0]        mul_cnt_reg, mul_cnt_next;
    logic              out_valid_reg, out_valid_next;

    // item datapath
    logic                  op_reg, op_next;
    logic [VW-1:0]         x_reg, x_next;
    pwli_pkg::point_t      last_reg, last_next;
    pwli_pkg::point_t      prev_reg, prev_next;
    logic [VW-1:0]         gap_reg, gap_next;
    logic [VW-1:0]         a_reg, a_next;
    logic                  neg_reg, neg_next;
    logic [VW-1:0]         big_reg, big_next;
    logic [SW-1:0]         small_reg, small_next;
    logic [PW-1:0]         acc_reg, acc_next;
    logic [VW-1:0]         res_reg, res_next;
    pwli_pkg::status_t     st_reg, st_next;
    logic [VW-1:0]         out_res_reg, out_res_next;
    pwli_pkg::status_t     out_st_reg, out_st_next;

    pwli_pkg::point_t      cur;
    logic                  hit;
    logic [VW-1:0]         gap_w, d_w, mag_w;
    logic                  neg_w;
    logic [VW+7:0]         prod;
    logic                  div_start, div_done;
    logic [VW-1:0]         div_q;

    assign cur   = pwli_pkg::map_point(bp_reg[idx_reg], op_reg);
    assign hit   = (prev_reg.dom <= x_reg) && (cur.dom >= x_reg);
    assign gap_w = cur.dom - prev_reg.dom;
    assign d_w   = x_reg - prev_reg.dom;
    assign neg_w = cur.rng < prev_reg.rng;
    assign mag_w = neg_w ? (prev_reg.rng - cur.rng) : (cur.rng - prev_reg.rng);
    assign prod  = (VW+8)'(big_reg) * (VW+8)'(small_reg[7:0]);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        mul_cnt_next   = mul_cnt_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        x_next         = x_reg;
        last_next      = last_reg;
        prev_next      = prev_reg;
        gap_next       = gap_reg;
        a_next         = a_reg;
        neg_next       = neg_reg;
        big_next       = big_reg;
        small_next     = small_reg;
        acc_next       = acc_reg;
        res_next       = res_reg;
        st_next        = st_reg;
        out_res_next   = out_res_reg;
        out_st_next    = out_st_reg;
        div_start      = 1'b0;

        if (rsp.valid && rsp.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            pwli_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.opcode;
                    x_next     = req.input_value;
                    idx_next   = n_last;
                    state_next = pwli_pkg::ST_HIGH;
                end
            end
            pwli_pkg::ST_HIGH:
            begin
                last_next  = cur;
                idx_next   = '0;
                state_next = pwli_pkg::ST_LOW;
            end
            pwli_pkg::ST_LOW:
            begin
                prev_next  = cur;
                idx_next   = IDX_W'(1);
                state_next = pwli_pkg::ST_SEARCH;
                if (!op_reg)
                begin
                    if (x_reg >= last_reg.dom)
                    begin
                        res_next   = last_reg.rng;
                        st_next    = pwli_pkg::STATUS_CLAMP_HIGH;
                        state_next = pwli_pkg::ST_DONE;
                    end
                    else if (x_reg <= cur.dom)
                    begin
                        res_next   = cur.rng;
                        st_next    = pwli_pkg::STATUS_CLAMP_LOW;
                        state_next = pwli_pkg::ST_DONE;
                    end
                end
                else
                begin
                    if (x_reg < cur.dom)
                    begin
                        res_next   = cur.rng;
                        st_next    = pwli_pkg::STATUS_CLAMP_LOW;
                        state_next = pwli_pkg::ST_DONE;
                    end
                    else if (x_reg > last_reg.dom)
                    begin
                        res_next   = last_reg.rng;
                        st_next    = pwli_pkg::STATUS_CLAMP_HIGH;
                        state_next = pwli_pkg::ST_DONE;
                    end
                end
            end
            pwli_pkg::ST_SEARCH:
            begin
                if (hit)
                begin
                    if (gap_w == '0)
                    begin
                        res_next   = '0;
                        st_next    = pwli_pkg::STATUS_FAULT;
                        state_next = pwli_pkg::ST_DONE;
                    end
                    else
                    begin
                        gap_next     = gap_w;
                        a_next       = prev_reg.rng;
                        neg_next     = neg_w;
                        // the narrow factor is the key-domain one: 24 bits
                        big_next     = op_reg ? d_w : mag_w;
                        small_next   = op_reg ? mag_w[SW-1:0] : d_w[SW-1:0];
                        acc_next     = '0;
                        mul_cnt_next = '0;
                        state_next   = pwli_pkg::ST_MUL;
                    end
                end
                else if (idx_reg == n_last)
                begin
                    res_next   = '0;
                    st_next    = pwli_pkg::STATUS_FAULT;
                    state_next = pwli_pkg::ST_DONE;
                end
                else
                begin
                    prev_next = cur;
                    idx_next  = idx_reg + IDX_W'(1);
                end
            end
            pwli_pkg::ST_MUL:
            begin
                acc_next     = acc_reg + (PW'(prod) << {mul_cnt_reg, 3'b000});
                small_next   = small_reg >> 8;
                mul_cnt_next = mul_cnt_reg + 2'd1;
                if (mul_cnt_reg == 2'(pwli_pkg::MUL_STEPS - 1))
                    state_next = pwli_pkg::ST_DIV;
            end
            pwli_pkg::ST_DIV:
            begin
                if (mul_cnt_reg == 2'(pwli_pkg::MUL_STEPS))
                begin
                    div_start    = 1'b1;
                    mul_cnt_next = '0;
                end
                else if (div_done)
                begin
                    res_next   = neg_reg ? (a_reg - div_q) : (a_reg + div_q);
                    st_next    = pwli_pkg::STATUS_INTERP;
                    state_next = pwli_pkg::ST_DONE;
                end
            end
            pwli_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    out_st_next    = st_reg;
                    state_next     = pwli_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pwli_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pwli_pkg::ST_IDLE;
            idx_reg       <= '0;
            mul_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            mul_cnt_reg   <= mul_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        x_reg       <= x_next;
        last_reg    <= last_next;
        prev_reg    <= prev_next;
        gap_reg     <= gap_next;
        a_reg       <= a_next;
        neg_reg     <= neg_next;
        big_reg     <= big_next;
        small_reg   <= small_next;
        acc_reg     <= acc_next;
        res_reg     <= res_next;
        st_reg      <= st_next;
        out_res_reg <= out_res_next;
        out_st_reg  <= out_st_next;
    end

    pwli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (gap_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign req.ready        = (state_reg == pwli_pkg::ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_res_reg;
    assign rsp.status       = out_st_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg == pwli_pkg::ST_HIGH)
        else $error("accepted item did not start the table walk");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == pwli_pkg::ST_DIV)
        else $error("divider finished outside the divide phase");

    a_search_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pwli_pkg::ST_SEARCH |-> idx_reg != '0 && idx_reg <= n_last)
        else $error("interval index outside the active table");

    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pwli_pkg::ST_DONE && (!out_valid_reg || rsp.ready)
        |=> rsp.valid && state_reg == pwli_pkg::ST_IDLE)
        else $error("finished item was not posted to the output register");

endmodule
`default_nettype wire

@@ tb/sv/pwli_interp_checker.sv @@
module pwli_interp_checker
    import pwli_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    pwli_req_if       req,
    pwli_rsp_if       rsp,
    pwli_cfg_if       cfg,
    output int        mismatches,
    output int        pending_results
);

    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic [VAL_W-1:0] result_value;
        status_t          status;
    } interp_result_t;

    logic [BP_W-1:0] bp_regs [NUM_BP_REGS];
    logic [PC_W-1:0] bp_count;
    interp_result_t  interp_results_due [$];
    int              errors = 0;

    function automatic interp_result_t interpolate(input logic inverse,
                                                   input logic [VAL_W-1:0] x);
        logic [VAL_W-1:0] axis [NUM_BP_REGS];
        logic [VAL_W-1:0] image [NUM_BP_REGS];
        logic [63:0]      delta;
        logic [63:0]      span;
        logic [63:0]      gap;
        logic [63:0]      quot;
        int               last;
        interp_result_t   r;
        for (int i = 0; i < NUM_BP_REGS; i++)
        begin
            axis[i]  = inverse ? bp_regs[i][VAL_W-1:0] : VAL_W'(bp_regs[i][BP_W-1:VAL_W]);
            image[i] = inverse ? VAL_W'(bp_regs[i][BP_W-1:VAL_W]) : bp_regs[i][VAL_W-1:0];
        end
        last = int'(bp_count) - 1;
        if (last < 1)
            last = 1;
        if (last > MAX_POINTS_DEFAULT - 1)
            last = MAX_POINTS_DEFAULT - 1;
        r.result_value = '0;
        r.status       = STATUS_FAULT;
        if (!inverse && x >= axis[last])
        begin
            r.result_value = image[last];
            r.status       = STATUS_CLAMP_HIGH;
        end
        else if (!inverse && x <= axis[0])
        begin
            r.result_value = image[0];
            r.status       = STATUS_CLAMP_LOW;
        end
        else if (inverse && x < axis[0])
        begin
            r.result_value = image[0];
            r.status       = STATUS_CLAMP_LOW;
        end
        else if (inverse && x > axis[last])
        begin
            r.result_value = image[last];
            r.status       = STATUS_CLAMP_HIGH;
        end
        else
        begin
            // first interval holding x wins, even in an unordered table
            for (int i = 0; i < last; i++)
            begin
                if (axis[i] <= x && axis[i+1] >= x)
                begin
                    gap = 64'(axis[i+1] - axis[i]);
                    if (gap != 0)
                    begin
                        delta = 64'(x - axis[i]);
                        span  = (image[i+1] >= image[i]) ? 64'(image[i+1] - image[i])
                                                         : 64'(image[i] - image[i+1]);
                        quot  = (delta * span) / gap;
                        r.result_value = (image[i+1] >= image[i]) ? image[i] + VAL_W'(quot)
                                                                  : image[i] - VAL_W'(quot);
                        r.status       = STATUS_INTERP;
                    end
                    break;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                   input logic [VAL_W-1:0] want);
        if (errors < PRINT_LIMIT)
            $display("[%0t] mismatch in %s: got 0x%h, expected 0x%h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        interp_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BP_REGS; i++)
                bp_regs[i] = BP_RESET[i];
            bp_count = POINT_COUNT_RESET;
            interp_results_due.delete();
        end
        else
        begin
            if (cfg.valid === 1'b1 && cfg.ready === 1'b1)
            begin
                if (cfg.addr < NUM_BP_REGS)
                    bp_regs[cfg.addr] = cfg.data;
                else if (cfg.addr == REG_POINT_COUNT)
                    bp_count = cfg.data[PC_W-1:0];
            end
            if (req.valid === 1'b1 && req.ready === 1'b1)
                interp_results_due.push_back(interpolate(req.opcode, req.input_value));
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                if (interp_results_due.size() == 0)
                    report_mismatch("unexpected result", rsp.result_value, '0);
                else
                begin
                    want = interp_results_due.pop_front();
                    if (rsp.result_value !== want.result_value)
                        report_mismatch("result_value", rsp.result_value, want.result_value);
                    if (rsp.status !== want.status)
                        report_mismatch("status", VAL_W'(rsp.status), VAL_W'(want.status));
                end
            end
        end
        pending_results <= interp_results_due.size();
        mismatches      <= errors;
    end

endmodule

@@ tb/sv/tb.sv @@
module tb;
    import pwli_pkg::*;

    localparam logic OP_KEY_TO_VALUE = 1'b0;
    localparam logic OP_VALUE_TO_KEY = 1'b1;
    localparam int   LIMIT_CYCLES    = 1_000_000;
    localparam int   DRAIN_CYCLES    = 60;
    localparam int   HOLD_CYCLES     = 400;
    localparam int   PHASE_ITEMS     = 190;

    typedef enum {
        SHAPE_RISING,
        SHAPE_FALLING,
        SHAPE_TWO_POINT,
        SHAPE_REPEATS,
        SHAPE_RAW,
        SHAPE_FULL_SPAN
    } table_shape_t;

    logic        clk;
    logic        rst_n;
    int          mismatches;
    int          pending_results;
    int unsigned cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_off = 1'b0;

    logic [BP_W-1:0] bp_regs [NUM_BP_REGS];
    logic [PC_W-1:0] bp_count;
    logic [BP_W-1:0] next_bp [NUM_BP_REGS];

    pwli_req_if req ();
    pwli_rsp_if rsp ();
    pwli_cfg_if cfg ();

    piecewise_linear_table_interp_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    pwli_interp_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req),
        .rsp             (rsp),
        .cfg             (cfg),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off when asked
    initial
    begin
        int held;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                rsp.ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [VAL_W-1:0] axis_point(input int i, input logic op);
        return (op == OP_VALUE_TO_KEY) ? bp_regs[i][VAL_W-1:0]
                                       : VAL_W'(bp_regs[i][BP_W-1:VAL_W]);
    endfunction

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_results != 0);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [BP_W-1:0] word);
        cfg.valid <= 1'b1;
        cfg.addr  <= idx;
        cfg.data  <= word;
        do
            @(posedge clk);
        while (cfg.ready !== 1'b1);
        if (idx < NUM_BP_REGS)
            bp_regs[idx] = word;
        else if (idx == REG_POINT_COUNT)
            bp_count = word[PC_W-1:0];
    endtask

    task automatic send_item(input logic op, input logic [VAL_W-1:0] x);
        req.valid       <= 1'b1;
        req.opcode      <= op;
        req.input_value <= x;
        do
            @(posedge clk);
        while (req.ready !== 1'b1);
    endtask

    task automatic send_random_item();
        logic             op;
        logic [VAL_W-1:0] lo;
        logic [VAL_W-1:0] hi;
        logic [VAL_W-1:0] swap;
        logic [VAL_W-1:0] x;
        int               n;
        int               pick;
        op   = $urandom_range(1) ? OP_VALUE_TO_KEY : OP_KEY_TO_VALUE;
        n    = (bp_count < 2) ? 2 : int'(bp_count);
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            lo = axis_point(pick % (n - 1), op);
            hi = axis_point(pick % (n - 1) + 1, op);
            if (lo > hi)
            begin
                swap = lo;
                lo   = hi;
                hi   = swap;
            end
            x = lo + VAL_W'(rand64() % (64'(hi - lo) + 64'd1));
        end
        else if (pick < 80)
            x = axis_point($urandom_range(n - 1), op);
        else
        begin
            x = VAL_W'(rand64());
            if (op == OP_KEY_TO_VALUE && pick < 90)
                x[VAL_W-1:KEY_W] = '0;
        end
        send_item(op, x);
    endtask

    task automatic build_table(input table_shape_t shape);
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
        logic [VAL_W-1:0] step;
        for (int i = 0; i < NUM_BP_REGS; i++)
        begin
            step = VAL_W'(rand64() & 64'h1F_FFFF_FFFF);
            if (i == 0)
            begin
                key = KEY_W'($urandom_range('h10_0000));
                val = (shape == SHAPE_FALLING) ? ~step : step;
            end
            else
            begin
                if (shape == SHAPE_REPEATS && $urandom_range(2) == 0)
                    step = '0;
                else
                    key = key + KEY_W'($urandom_range('h24_0000));
                val = (shape == SHAPE_FALLING) ? val - step : val + step;
            end
            next_bp[i] = (shape == SHAPE_RAW) ? rand64() : {key, val};
        end
        if (shape == SHAPE_TWO_POINT)
        begin
            next_bp[0] = '0;
            next_bp[1] = '1;
        end
        if (shape == SHAPE_FULL_SPAN)
        begin
            next_bp[0]             = '0;
            next_bp[NUM_BP_REGS-1] = '1;
        end
    endtask

    task automatic run_phase(input table_shape_t shape, input logic [BP_W-1:0] count_word,
                             input int idle_pct, input int stall_pct, input bit squeeze);
        wait_idle();
        build_table(shape);
        for (int i = 0; i < NUM_BP_REGS; i++)
            cfg_write(CFG_ADDR_W'(i), next_bp[i]);
        cfg_write(REG_POINT_COUNT, count_word);
        cfg.valid <= 1'b0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        hold_off       = squeeze;
        for (int k = 0; k < PHASE_ITEMS; k++)
        begin
            send_random_item();
            if ($urandom_range(99) < send_idle_pct)
            begin
                req.valid <= 1'b0;
                repeat ($urandom_range(1, 60))
                    @(posedge clk);
            end
        end
        if (req.valid)
            req.valid <= 1'b0;
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        req.valid       <= 1'b0;
        req.opcode      <= OP_KEY_TO_VALUE;
        req.input_value <= '0;
        cfg.valid       <= 1'b0;
        cfg.addr        <= '0;
        cfg.data        <= '0;
        for (int i = 0; i < NUM_BP_REGS; i++)
            bp_regs[i] = BP_RESET[i];
        bp_count = POINT_COUNT_RESET;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset table: keys ascending, values ascending too
        send_item(OP_KEY_TO_VALUE, '0);
        send_item(OP_KEY_TO_VALUE, '1);
        send_item(OP_KEY_TO_VALUE, 40'h00_00FF_FFFF);
        send_item(OP_KEY_TO_VALUE, 40'h00_0100_0000);
        send_item(OP_KEY_TO_VALUE, 40'h00_0005_0000);
        send_item(OP_VALUE_TO_KEY, '0);
        send_item(OP_VALUE_TO_KEY, 40'h00_0000_0001);
        send_item(OP_VALUE_TO_KEY, '1);
        req.valid <= 1'b0;
        wait_idle();

        // repeated key, non-monotone values, equal neighbor values
        cfg_write(CFG_ADDR_W'(0), {24'h00_0000, 40'h00_0000_0100});
        cfg_write(CFG_ADDR_W'(1), {24'h10_0000, 40'hFF_FFFF_FFFF});
        cfg_write(CFG_ADDR_W'(2), {24'h10_0000, 40'h80_0000_0000});
        cfg_write(CFG_ADDR_W'(3), {24'h40_0000, 40'h00_0000_0000});
        cfg_write(CFG_ADDR_W'(4), {24'h80_0000, 40'h12_3456_7890});
        cfg_write(CFG_ADDR_W'(5), {24'hC0_0000, 40'h12_3456_7890});
        cfg_write(CFG_ADDR_W'(6), {24'hFF_FFFF, 40'h00_FFFF_FF00});
        cfg_write(REG_POINT_COUNT, 64'd7);
        // indexes past the register list must be ignored
        cfg_write(REG_POINT_COUNT + CFG_ADDR_W'(1), '1);
        cfg_write('1, '0);
        cfg.valid <= 1'b0;
        for (int i = 0; i < NUM_BP_REGS; i++)
        begin
            send_item(OP_KEY_TO_VALUE, axis_point(i, OP_KEY_TO_VALUE));
            send_item(OP_VALUE_TO_KEY, axis_point(i, OP_VALUE_TO_KEY));
        end
        send_item(OP_KEY_TO_VALUE, 40'h00_0061_2345);
        send_item(OP_VALUE_TO_KEY, 40'h90_0000_0000);
        send_item(OP_VALUE_TO_KEY, 40'h00_0000_0080);
        req.valid <= 1'b0;

        run_phase(SHAPE_RISING,    64'd7,                  0,  0,  1'b0);
        run_phase(SHAPE_FALLING,   '1,                     66, 0,  1'b0);
        run_phase(SHAPE_TWO_POINT, 64'd2,                  0,  66, 1'b0);
        run_phase(SHAPE_REPEATS,   64'd5,                  29, 29, 1'b1);
        run_phase(SHAPE_RAW,       64'd0,                  0,  0,  1'b0);
        run_phase(SHAPE_RISING,    64'hFFFF_FFFF_FFFF_FFF3, 66, 0,  1'b0);
        run_phase(SHAPE_FALLING,   64'd6,                  0,  66, 1'b1);
        run_phase(SHAPE_FULL_SPAN, 64'd1,                  29, 29, 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0 && pending_results == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/pwli_pkg.sv
hw/rtl/pwli_ifs.sv
hw/rtl/pwli_div.sv
hw/rtl/piecewise_linear_table_interp_core.sv
tb/sv/pwli_interp_checker.sv
tb/sv/tb.sv
